### hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked only while out of reset
`define AURF_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked at every edge, reset included
`define AURF_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define AURF_ASSERT_RST(lbl, clk, rst_n, prop)
`define AURF_ASSERT_ALL(lbl, clk, prop)

`endif

`endif

### hw/rtl/aurf_pkg.sv
// types, constants and helpers of the advertising report uuid filter
package aurf_pkg;

    localparam int UUID_W     = 64;
    localparam int ADDR_W     = 48;
    localparam int AKIND_W    = 2;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int FULL_ADDR_W = ADDR_W + AKIND_W;

    localparam logic [UUID_W-1:0] UUID_RESET  = 64'h1111_1111_1111_1111;
    localparam logic [7:0]        TYPE_UUID128 = 8'h07;
    localparam logic [7:0]        UUID_LEN_BYTE = 8'h11;
    localparam logic [3:0]        UUID_LAST_IDX = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_UUID_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UUID_HIGH = 1'b1;

    localparam logic [KIND_W-1:0] ADV_KIND_CONN_UNDIR = 3'd0;
    localparam logic [KIND_W-1:0] ADV_KIND_DIRECT     = 3'd1;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT   = 2'd0,
        VERDICT_BAD_KIND = 2'd1,
        VERDICT_NO_UUID  = 2'd2,
        VERDICT_REPEAT   = 2'd3
    } t_verdict;

    // one accepted input word
    typedef struct packed {
        logic [7:0]         ad_byte;
        logic               first_byte;
        logic               last_byte;
        logic [KIND_W-1:0]  adv_kind;
        logic [ADDR_W-1:0]  peer_address;
        logic [AKIND_W-1:0] peer_address_kind;
        logic               prior_read_done;
    } t_item;

    // control from the input stage to the parser and verdict logic
    typedef struct packed {
        logic advance;
        logic first;
        logic last;
    } t_step_ctl;

    // byte idx of the 128-bit target, byte 0 in bits 7..0 of the low word
    function automatic logic [7:0] target_byte(
        input logic [UUID_W-1:0] lo,
        input logic [UUID_W-1:0] hi,
        input logic [3:0]        idx
    );
        logic [2*UUID_W-1:0] full;
        full = {hi, lo};
        return full[{idx, 3'b000} +: 8];
    endfunction

endpackage

### hw/rtl/aurf_parser.sv
// length-type-value walker that detects the target 128-bit uuid
module aurf_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  aurf_pkg::t_step_ctl         i_ctl,
    input  logic [7:0]                  i_ad_byte,
    input  logic [aurf_pkg::UUID_W-1:0] i_uuid_low,
    input  logic [aurf_pkg::UUID_W-1:0] i_uuid_high,
    output logic                        o_found
);
    import aurf_pkg::*;

    t_phase      r_phase, n_phase, cur_phase;
    logic [7:0]  r_bytes_left, n_bytes_left, cur_bytes_left, dec_bytes_left;
    logic        r_cand, n_cand, cur_cand;
    logic [3:0]  r_idx, n_idx, cur_idx;
    logic        r_eq, n_eq, cur_eq;
    logic        r_found, n_found, cur_found;
    logic        byte_match;

    // a first byte starts from cleared parse state
    always_comb begin
        cur_phase      = i_ctl.first ? PH_LEN : r_phase;
        cur_bytes_left = i_ctl.first ? 8'd0 : r_bytes_left;
        cur_cand       = i_ctl.first ? 1'b0 : r_cand;
        cur_idx        = i_ctl.first ? 4'd0 : r_idx;
        cur_eq         = i_ctl.first ? 1'b0 : r_eq;
        cur_found      = i_ctl.first ? 1'b0 : r_found;
        dec_bytes_left = cur_bytes_left - 8'd1;
        byte_match     = (i_ad_byte == target_byte(i_uuid_low, i_uuid_high, cur_idx));
    end

    // next phase
    always_comb begin
        n_phase = cur_phase;
        case (cur_phase)
            PH_LEN: begin
                n_phase = (i_ad_byte == 8'd0) ? PH_STOP : PH_TYPE;
            end
            PH_TYPE: begin
                n_phase = (dec_bytes_left != 8'd0) ? PH_DATA : PH_LEN;
            end
            PH_DATA: begin
                n_phase = (dec_bytes_left != 8'd0) ? PH_DATA : PH_LEN;
            end
            PH_STOP: begin
                n_phase = PH_STOP;
            end
            default: begin
                n_phase = PH_LEN;
            end
        endcase
    end

    // structure bookkeeping and compare
    always_comb begin
        n_bytes_left = cur_bytes_left;
        n_cand       = cur_cand;
        n_idx        = cur_idx;
        n_eq         = cur_eq;
        n_found      = cur_found;
        case (cur_phase)
            PH_LEN: begin
                if (i_ad_byte != 8'd0) begin
                    n_bytes_left = i_ad_byte;
                end
            end
            PH_TYPE: begin
                n_cand       = (i_ad_byte == TYPE_UUID128) && (cur_bytes_left == UUID_LEN_BYTE);
                n_bytes_left = dec_bytes_left;
                n_idx        = 4'd0;
                n_eq         = 1'b1;
            end
            PH_DATA: begin
                if (cur_cand) begin
                    n_eq  = cur_eq && byte_match;
                    n_idx = cur_idx + 4'd1;
                    if ((cur_idx == UUID_LAST_IDX) && cur_eq && byte_match) begin
                        n_found = 1'b1;
                    end
                end
                n_bytes_left = dec_bytes_left;
            end
            PH_STOP: begin
                n_bytes_left = cur_bytes_left;
            end
            default: begin
                n_bytes_left = cur_bytes_left;
            end
        endcase
    end

    assign o_found = n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_bytes_left <= 8'd0;
            r_cand       <= 1'b0;
            r_idx        <= 4'd0;
            r_eq         <= 1'b0;
            r_found      <= 1'b0;
        end else if (i_ctl.advance) begin
            if (i_ctl.last) begin
                r_phase      <= PH_LEN;
                r_bytes_left <= 8'd0;
                r_cand       <= 1'b0;
                r_idx        <= 4'd0;
                r_eq         <= 1'b0;
                r_found      <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_cand       <= n_cand;
                r_idx        <= n_idx;
                r_eq         <= n_eq;
                r_found      <= n_found;
            end
        end
    end

endmodule

### hw/rtl/aurf_verdict.sv
// report verdict and last accepted address
module aurf_verdict (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  aurf_pkg::t_step_ctl          i_ctl,
    input  logic [aurf_pkg::KIND_W-1:0]  i_adv_kind,
    input  logic [aurf_pkg::ADDR_W-1:0]  i_peer_address,
    input  logic [aurf_pkg::AKIND_W-1:0] i_peer_address_kind,
    input  logic                         i_prior_read_done,
    input  logic                         i_found,
    output aurf_pkg::t_verdict           o_verdict
);
    import aurf_pkg::*;

    logic [FULL_ADDR_W-1:0] r_last_addr;
    logic [FULL_ADDR_W-1:0] full_addr;
    logic                   kind_ok;

    assign full_addr = {i_peer_address_kind, i_peer_address};
    assign kind_ok   = (i_adv_kind == ADV_KIND_CONN_UNDIR) || (i_adv_kind == ADV_KIND_DIRECT);

    // wrong kind first, then missing uuid, then repeat device
    always_comb begin
        if (!kind_ok) begin
            o_verdict = VERDICT_BAD_KIND;
        end else if (!i_found) begin
            o_verdict = VERDICT_NO_UUID;
        end else if (i_prior_read_done && (full_addr == r_last_addr)) begin
            o_verdict = VERDICT_REPEAT;
        end else begin
            o_verdict = VERDICT_ACCEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_addr <= '0;
        end else if (i_ctl.advance && i_ctl.last && (o_verdict == VERDICT_ACCEPT)) begin
            r_last_addr <= full_addr;
        end
    end

endmodule

### hw/rtl/adv_report_uuid_filter.sv
// top level of the advertising report uuid filter
//
//  channel   direction  handshake                 word
//  input     in         i_valid / o_stall         ad byte, flags, kind, address, prior flag
//  result    out        o_valid / i_stall         accepted, verdict
//  config    in         i_cfg_valid / o_cfg_ready  register index, 64-bit data
//
// one word per cycle sustained while no stall holds it: an input register, the parse and
// verdict logic, then a result register
// reset is synchronous, active low; it clears the parse state, the last
// accepted address and both stages, and loads the uuid registers with 0x11 bytes
// only a last byte needs the result register; other words pass even while the
// output is stalled, so the input stalls only on a last byte facing a full,
// stalled result register
`include "assert_macros.svh"

module adv_report_uuid_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_ad_byte,
    input  logic                         i_first_byte,
    input  logic                         i_last_byte,
    input  logic [aurf_pkg::KIND_W-1:0]  i_adv_kind,
    input  logic [aurf_pkg::ADDR_W-1:0]  i_peer_address,
    input  logic [aurf_pkg::AKIND_W-1:0] i_peer_address_kind,
    input  logic                         i_prior_read_done,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_accepted,
    output logic [1:0]                   o_verdict,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [aurf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aurf_pkg::UUID_W-1:0]  i_cfg_data
);
    import aurf_pkg::*;

    // configuration registers
    logic [UUID_W-1:0] r_uuid_low;
    logic [UUID_W-1:0] r_uuid_high;

    // input stage
    logic              r_in_vld;
    t_item             r_in;

    // result stage
    logic              r_out_vld;
    logic              r_out_accepted;
    t_verdict          r_out_verdict;

    t_step_ctl         ctl;
    logic              advance;
    logic              in_take;
    logic              found;
    t_verdict          verdict;

    // a word leaves the input register unless it is a last byte that has no
    // room in the result register
    assign advance = r_in_vld && (!r_in.last_byte || !r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !advance;
    assign in_take = i_valid && !o_stall;

    assign ctl.advance = advance;
    assign ctl.first   = r_in.first_byte;
    assign ctl.last    = r_in.last_byte;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uuid_low  <= UUID_RESET;
            r_uuid_high <= UUID_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UUID_LOW: begin
                    r_uuid_low <= i_cfg_data;
                end
                CFG_UUID_HIGH: begin
                    r_uuid_high <= i_cfg_data;
                end
                default: begin
                    r_uuid_low <= r_uuid_low;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.ad_byte           <= i_ad_byte;
            r_in.first_byte        <= i_first_byte;
            r_in.last_byte         <= i_last_byte;
            r_in.adv_kind          <= i_adv_kind;
            r_in.peer_address      <= i_peer_address;
            r_in.peer_address_kind <= i_peer_address_kind;
            r_in.prior_read_done   <= i_prior_read_done;
        end
    end

    aurf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_ad_byte   (r_in.ad_byte),
        .i_uuid_low  (r_uuid_low),
        .i_uuid_high (r_uuid_high),
        .o_found     (found)
    );

    aurf_verdict u_verdict (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (ctl),
        .i_adv_kind          (r_in.adv_kind),
        .i_peer_address      (r_in.peer_address),
        .i_peer_address_kind (r_in.peer_address_kind),
        .i_prior_read_done   (r_in.prior_read_done),
        .i_found             (found),
        .o_verdict           (verdict)
    );

    // result register, loaded only by a last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && r_in.last_byte) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last_byte) begin
            r_out_accepted <= (verdict == VERDICT_ACCEPT);
            r_out_verdict  <= verdict;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_accepted = r_out_accepted;
    assign o_verdict  = r_out_verdict;

    // accepted flag agrees with the verdict code
    `AURF_ASSERT_RST(a_accept_matches, i_clk, i_rst_n,
        o_valid |-> (o_accepted == (o_verdict == VERDICT_ACCEPT)))
    // a last byte that leaves the input stage shows up as a result
    `AURF_ASSERT_RST(a_last_gives_result, i_clk, i_rst_n, (advance && r_in.last_byte) |=> o_valid)
    // the input only stalls behind a held word
    `AURF_ASSERT_ALL(a_stall_needs_word, i_clk, o_stall |-> r_in_vld)

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the advertising report uuid filter

module testbench;
    import aurf_pkg::*;

    // adv kind value outside the two accepted kinds, an unknown pdu type
    localparam logic [KIND_W-1:0] ADV_KIND_UNKNOWN_TOP = 3'd4;
    // cycles the result side holds off in one go to back the block up
    localparam int LONG_HOLD_CYCLES = 300;
    // words of random reports per configuration phase
    localparam int PHASE_WORDS = 270;

    typedef struct packed {
        logic     accepted;
        t_verdict verdict;
    } t_due_verdict;

    // tracks the parse of each report and predicts the verdict of its last byte
    class verdict_board;
        logic [UUID_W-1:0]      uuid_lo;
        logic [UUID_W-1:0]      uuid_hi;
        t_phase                 phase;
        logic [7:0]             left;
        logic                   candidate;
        logic [3:0]             idx;
        logic                   equal_so_far;
        logic                   found;
        logic [FULL_ADDR_W-1:0] last_accepted;
        t_due_verdict           verdicts_due[$];
        int                     errors;

        function new();
            uuid_lo       = UUID_RESET;
            uuid_hi       = UUID_RESET;
            last_accepted = '0;
            errors        = 0;
            restart();
        endfunction

        function void restart();
            phase        = PH_LEN;
            left         = 8'd0;
            candidate    = 1'b0;
            idx          = 4'd0;
            equal_so_far = 1'b0;
            found        = 1'b0;
        endfunction

        function void set_target(logic [CFG_IDX_W-1:0] sel, logic [UUID_W-1:0] value);
            if (sel == CFG_UUID_LOW) begin
                uuid_lo = value;
            end else begin
                uuid_hi = value;
            end
        endfunction

        function logic [7:0] target_at(logic [3:0] n);
            logic [UUID_W-1:0] half;
            half = n[3] ? uuid_hi : uuid_lo;
            return 8'(half >> (8 * n[2:0]));
        endfunction

        function void take_word(t_item w);
            logic [FULL_ADDR_W-1:0] full;
            t_due_verdict           entry;
            if (w.first_byte) restart();
            case (phase)
                PH_LEN: begin
                    if (w.ad_byte == 8'd0) begin
                        phase = PH_STOP;
                    end else begin
                        left  = w.ad_byte;
                        phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    candidate    = (w.ad_byte == TYPE_UUID128) && (left == UUID_LEN_BYTE);
                    left         = left - 8'd1;
                    idx          = 4'd0;
                    equal_so_far = 1'b1;
                    phase        = (left != 8'd0) ? PH_DATA : PH_LEN;
                end
                PH_DATA: begin
                    if (candidate) begin
                        if (w.ad_byte != target_at(idx)) equal_so_far = 1'b0;
                        if (idx == UUID_LAST_IDX && equal_so_far) found = 1'b1;
                        idx = idx + 4'd1;
                    end
                    left = left - 8'd1;
                    if (left == 8'd0) phase = PH_LEN;
                end
                default: ;
            endcase
            if (!w.last_byte) return;
            full = {w.peer_address_kind, w.peer_address};
            if (w.adv_kind != ADV_KIND_CONN_UNDIR && w.adv_kind != ADV_KIND_DIRECT) begin
                entry.verdict = VERDICT_BAD_KIND;
            end else if (!found) begin
                entry.verdict = VERDICT_NO_UUID;
            end else if (w.prior_read_done && full == last_accepted) begin
                entry.verdict = VERDICT_REPEAT;
            end else begin
                entry.verdict = VERDICT_ACCEPT;
                last_accepted = full;
            end
            entry.accepted = (entry.verdict == VERDICT_ACCEPT);
            verdicts_due.push_back(entry);
            restart();
        endfunction

        function void match_verdict(logic acc, logic [1:0] v);
            t_due_verdict want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result, accepted %0b verdict %0d", $time, acc, v);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (acc !== want.accepted) begin
                $display("%0t: accepted expected %0b actual %0b", $time, want.accepted, acc);
                errors++;
            end
            if (v !== want.verdict) begin
                $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, v);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [7:0]             i_ad_byte;
    logic                   i_first_byte;
    logic                   i_last_byte;
    logic [KIND_W-1:0]      i_adv_kind;
    logic [ADDR_W-1:0]      i_peer_address;
    logic [AKIND_W-1:0]     i_peer_address_kind;
    logic                   i_prior_read_done;
    logic                   o_valid;
    logic                   i_stall;
    logic                   o_accepted;
    logic [1:0]             o_verdict;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [UUID_W-1:0]      i_cfg_data;

    verdict_board           board;
    logic [7:0]             report_bytes[$];  // ad bytes of the report being built
    int                     restart_at;       // byte that raises first_byte mid report, -1 none
    int                     words_sent;
    logic [ADDR_W-1:0]      addr_pool[4];     // small pool so repeat devices show up
    logic [AKIND_W-1:0]     akind_pool[4];
    bit                     steady;           // no idling on either side while set
    int                     hold_requests;    // bumped by the stimulus to ask for a long hold
    int                     holds_taken;
    int                     hold_left;

    adv_report_uuid_filter i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_ad_byte           (i_ad_byte),
        .i_first_byte        (i_first_byte),
        .i_last_byte         (i_last_byte),
        .i_adv_kind          (i_adv_kind),
        .i_peer_address      (i_peer_address),
        .i_peer_address_kind (i_peer_address_kind),
        .i_prior_read_done   (i_prior_read_done),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_accepted          (o_accepted),
        .o_verdict           (o_verdict),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // 12 ns clock, first rising edge at 6 ns
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        return {a[15:0], b};
    endfunction

    function automatic logic [UUID_W-1:0] rand_uuid_half();
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        return {a, b};
    endfunction

    // one word onto the input channel; random idle cycles ahead of it, then
    // hold it until a rising edge sees valid high and stall low
    task automatic put_word(input t_item w);
        while (!steady && $urandom_range(99, 0) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_ad_byte           <= w.ad_byte;
        i_first_byte        <= w.first_byte;
        i_last_byte         <= w.last_byte;
        i_adv_kind          <= w.adv_kind;
        i_peer_address      <= w.peer_address;
        i_peer_address_kind <= w.peer_address_kind;
        i_prior_read_done   <= w.prior_read_done;
        do @(posedge i_clk); while (o_stall);
        board.take_word(w);
        words_sent++;
    endtask

    // sends report_bytes as one report; the sideband fields only count on the
    // last byte, so the earlier bytes carry junk there
    task automatic send_report(input logic mark_first, input logic [KIND_W-1:0] kind,
                               input logic [ADDR_W-1:0] addr,
                               input logic [AKIND_W-1:0] akind, input logic prior);
        t_item w;
        for (int j = 0; j < report_bytes.size(); j++) begin
            w.ad_byte    = report_bytes[j];
            w.first_byte = (j == 0) ? mark_first : (j == restart_at);
            w.last_byte  = (j == report_bytes.size() - 1);
            if (w.last_byte) begin
                w.adv_kind          = kind;
                w.peer_address      = addr;
                w.peer_address_kind = akind;
                w.prior_read_done   = prior;
            end else begin
                w.adv_kind          = KIND_W'($urandom_range(7, 0));
                w.peer_address      = rand_addr();
                w.peer_address_kind = AKIND_W'($urandom_range(3, 0));
                w.prior_read_done   = 1'($urandom_range(1, 0));
            end
            put_word(w);
        end
        restart_at = -1;
    endtask

    // uuid list structure carrying the current target, one byte spoiled on request
    function automatic void add_uuid_structure(input bit spoil);
        int          bad;
        logic [7:0]  b;
        bad = spoil ? $urandom_range(15, 0) : -1;
        report_bytes.push_back(UUID_LEN_BYTE);
        report_bytes.push_back(TYPE_UUID128);
        for (int k = 0; k < 16; k++) begin
            b = board.target_at(4'(k));
            if (k == bad) b = b ^ 8'($urandom_range(255, 1));
            report_bytes.push_back(b);
        end
    endfunction

    // random structure; a long length swallows the rest of the report
    function automatic void add_plain_structure();
        int len;
        len = ($urandom_range(9, 0) != 0) ? $urandom_range(10, 1) : $urandom_range(255, 11);
        report_bytes.push_back(8'(len));
        report_bytes.push_back(8'($urandom_range(255, 0)));
        for (int k = 1; k < len && k < 24; k++) report_bytes.push_back(8'($urandom_range(255, 0)));
    endfunction

    // target bytes behind a wrong type, or a uuid type with the wrong length
    function automatic void add_lookalike_structure();
        int len;
        if ($urandom_range(1, 0) != 0) begin
            report_bytes.push_back(UUID_LEN_BYTE);
            report_bytes.push_back(TYPE_UUID128 ^ 8'($urandom_range(255, 1)));
            for (int k = 0; k < 16; k++) report_bytes.push_back(board.target_at(4'(k)));
        end else begin
            len = ($urandom_range(3, 0) == 0) ? 18 : $urandom_range(16, 2);
            report_bytes.push_back(8'(len));
            report_bytes.push_back(TYPE_UUID128);
            for (int k = 1; k < len; k++) report_bytes.push_back(board.target_at(4'(k % 16)));
        end
    endfunction

    function automatic void build_report();
        int parts;
        int r;
        int keep;
        report_bytes.delete();
        restart_at = -1;
        if ($urandom_range(99, 0) < 5) begin
            // plain noise
            repeat ($urandom_range(20, 1)) report_bytes.push_back(8'($urandom_range(255, 0)));
        end else begin
            parts = $urandom_range(3, 1);
            repeat (parts) begin
                r = $urandom_range(99, 0);
                if (r < 40) add_uuid_structure(1'b0);
                else if (r < 55) add_uuid_structure(1'b1);
                else if (r < 80) add_plain_structure();
                else if (r < 92) add_lookalike_structure();
                else report_bytes.push_back(8'h00);  // zero length, rest is ignored
            end
            // cut the report short, often inside a structure
            if ($urandom_range(99, 0) < 10 && report_bytes.size() > 1) begin
                keep = $urandom_range(report_bytes.size() - 1, 1);
                while (report_bytes.size() > keep) void'(report_bytes.pop_back());
            end
        end
        // a first-byte flag in the middle starts the parse over
        if ($urandom_range(99, 0) < 4 && report_bytes.size() > 1)
            restart_at = $urandom_range(report_bytes.size() - 1, 1);
    endfunction

    task automatic wait_results();
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    // drain the block: all verdicts in, then a short wait for the pipe
    task automatic settle();
        i_valid <= 1'b0;
        wait_results();
        repeat (4) @(posedge i_clk);
    endtask

    // writes both target registers, valid held across the pair
    task automatic load_target(input logic [UUID_W-1:0] lo, input logic [UUID_W-1:0] hi);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_UUID_LOW;
        i_cfg_data  <= lo;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_target(CFG_UUID_LOW, lo);
        i_cfg_index <= CFG_UUID_HIGH;
        i_cfg_data  <= hi;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_target(CFG_UUID_HIGH, hi);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_reports();
        // full match on the reset target, directed pdu, all-ones address
        report_bytes.delete();
        add_uuid_structure(1'b0);
        send_report(1'b1, ADV_KIND_DIRECT, '1, 2'd3, 1'b1);
        // zero length byte with an unknown pdu type: wrong type comes first
        report_bytes.delete();
        report_bytes.push_back(8'h00);
        send_report(1'b1, ADV_KIND_UNKNOWN_TOP, '0, 2'd0, 1'b0);
        // same device as just accepted but no uuid: absent outranks repeat
        report_bytes.delete();
        report_bytes.push_back(8'hFF);
        send_report(1'b1, ADV_KIND_CONN_UNDIR, '1, 2'd3, 1'b1);
        // uuid structure cut off by the report end
        report_bytes.delete();
        report_bytes.push_back(UUID_LEN_BYTE);
        report_bytes.push_back(TYPE_UUID128);
        report_bytes.push_back(board.target_at(4'd0));
        send_report(1'b1, ADV_KIND_CONN_UNDIR, rand_addr(), 2'd1, 1'b0);
        // new report with no first-byte flag, relying on the clear at report end
        report_bytes.delete();
        report_bytes.push_back(8'h00);
        send_report(1'b0, ADV_KIND_DIRECT, '0, 2'd2, 1'b1);
    endtask

    task automatic random_reports(input int words, input int pause_after);
        int                 start;
        int                 pick;
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  addr;
        logic [AKIND_W-1:0] akind;
        start = words_sent;
        while (words_sent - start < words) begin
            // sender pause until every verdict is back
            if (pause_after >= 0 && words_sent - start >= pause_after) begin
                pause_after = -1;
                i_valid <= 1'b0;
                wait_results();
            end
            build_report();
            kind = ($urandom_range(99, 0) < 80) ? KIND_W'($urandom_range(1, 0))
                                                : KIND_W'($urandom_range(7, 2));
            pick = $urandom_range(5, 0);
            if (pick < 4) begin
                addr  = addr_pool[pick];
                akind = akind_pool[pick];
            end else begin
                addr  = rand_addr();
                akind = AKIND_W'($urandom_range(3, 0));
            end
            send_report($urandom_range(9, 0) != 0, kind, addr, akind,
                        $urandom_range(99, 0) < 60);
        end
    endtask

    // result side: check every result taken, stall at random, and take a
    // long hold whenever the stimulus asks for one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_valid && !i_stall) board.match_verdict(o_accepted, o_verdict);
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (holds_taken != hold_requests) begin
                holds_taken <= hold_requests;
                hold_left   <= LONG_HOLD_CYCLES;
                i_stall     <= 1'b1;
            end else begin
                i_stall <= !steady && ($urandom_range(99, 0) < 27);
            end
        end
    end

    initial begin
        board         = new();
        steady        = 1'b0;
        restart_at    = -1;
        words_sent    = 0;
        hold_requests = 0;
        holds_taken   = 0;
        hold_left     = 0;
        for (int k = 0; k < 4; k++) begin
            addr_pool[k]  = rand_addr();
            akind_pool[k] = AKIND_W'(k);
        end
        // two pool entries share an address and differ only in address kind
        addr_pool[1] = addr_pool[0];

        i_rst_n             <= 1'b0;
        i_valid             <= 1'b0;
        i_stall             <= 1'b0;
        i_ad_byte           <= '0;
        i_first_byte        <= 1'b0;
        i_last_byte         <= 1'b0;
        i_adv_kind          <= '0;
        i_peer_address      <= '0;
        i_peer_address_kind <= '0;
        i_prior_read_done   <= 1'b0;
        i_cfg_valid         <= 1'b0;
        i_cfg_index         <= CFG_UUID_LOW;
        i_cfg_data          <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset target first
        directed_reports();
        random_reports(PHASE_WORDS, -1);
        settle();

        // all-zero target; the result side holds off at the start so the
        // block backs up and stalls its input
        load_target('0, '0);
        hold_requests <= hold_requests + 1;
        random_reports(PHASE_WORDS, -1);
        settle();

        // all-ones target, with a sender pause halfway
        load_target('1, '1);
        random_reports(PHASE_WORDS, PHASE_WORDS / 2);
        settle();

        // random target, both sides at full rate
        load_target(rand_uuid_half(), rand_uuid_half());
        steady = 1'b1;
        random_reports(PHASE_WORDS, -1);
        settle();
        steady = 1'b0;

        // random high half against the reset low half
        load_target(UUID_RESET, rand_uuid_half());
        random_reports(PHASE_WORDS, -1);
        settle();
        repeat (8) @(posedge i_clk);

        if (board.errors == 0 && board.verdicts_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
